// ----- hdl/adx_adpcm_decoder_defines.svh -----
// Assertion macros for the ADX ADPCM decoder checker.
`ifndef ADX_ADPCM_DECODER_DEFINES_SVH
`define ADX_ADPCM_DECODER_DEFINES_SVH

// Consequent in the next cycle, ignored while reset is asserted.
`define ADX_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Consequent in the next cycle, checked during reset as well.
`define ADX_ASSERT_NEXT_ALWAYS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/adx_pkg.sv -----
// Shared types and constants for the ADX ADPCM decoder.
package adx_pkg;

  localparam int NUM_CHANNELS_DEF = 2;
  localparam int FRAME_BYTES_DEF  = 18;
  localparam int QUEUE_DEPTH      = 2;

  localparam int BYTE_W   = 8;
  localparam int SCALE_W  = 17;
  localparam int COEF_W   = 13;
  localparam int SAMPLE_W = 16;
  localparam int CFG_IDX_W = 1;

  localparam int PRED_SHIFT = 12;
  localparam int SAMPLE_MAX = 32767;
  localparam int SAMPLE_MIN = -32768;

  localparam logic [COEF_W-1:0] COEF_ONE_RST = 13'd7334;
  localparam logic [COEF_W-1:0] COEF_TWO_RST = 13'h132C; // -3284

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COEF_ONE = 1'b0,
    REG_COEF_TWO = 1'b1
  } cfg_reg_t;

  // One data byte waiting for decode, with the scale of its frame.
  typedef struct packed {
    logic [BYTE_W-1:0]  data_byte;
    logic               chan_sel;
    logic [SCALE_W-1:0] scale;
  } adx_item_t;

  typedef struct packed {
    logic      valid;
    adx_item_t item;
  } adx_push_t;

endpackage

// ----- hdl/adx_adpcm_decoder.sv -----
// Top level of the ADX 4-bit ADPCM decoder.
//
//   port group   dir   beat contents
//   in_*         in    data_byte, chan_sel (one frame byte)
//   out_*        out   pcm_sample, chan_out, last_of_byte (one sample)
//   cfg_*        in    cfg_idx selects coefficient, cfg_wdata value
//
// The decode core handles each data byte one nibble at a time, high nibble first, since the
// low nibble's prediction needs the high nibble's sample in the channel history.
// Scale bytes are consumed by the front end and produce no output.
// Synchronous active-low reset clears frame position, scale, history and queue.
// A stalled output holds the core; the 2-entry queue lets input run on until full.
module adx_adpcm_decoder #(
  parameter int NUM_CHANNELS = adx_pkg::NUM_CHANNELS_DEF,
  parameter int FRAME_BYTES  = adx_pkg::FRAME_BYTES_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [adx_pkg::BYTE_W-1:0]          in_data_byte,
  input  logic                                in_chan_sel,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [adx_pkg::SAMPLE_W-1:0] out_pcm_sample,
  output logic                                out_chan_out,
  output logic                                out_last_of_byte,
  input  logic                                cfg_we,
  input  logic [adx_pkg::CFG_IDX_W-1:0]       cfg_idx,
  input  logic [adx_pkg::COEF_W-1:0]          cfg_wdata
);

  logic [adx_pkg::COEF_W-1:0]        coef_one_r;
  logic signed [adx_pkg::COEF_W-1:0] coef_two_r;
  adx_pkg::adx_push_t                push;
  adx_pkg::adx_item_t                q_item;
  logic                              q_full, q_valid, q_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_one_r <= adx_pkg::COEF_ONE_RST;
      coef_two_r <= adx_pkg::COEF_TWO_RST;
    end else if (cfg_we) begin
      case (adx_pkg::cfg_reg_t'(cfg_idx))
        adx_pkg::REG_COEF_ONE: coef_one_r <= cfg_wdata;
        adx_pkg::REG_COEF_TWO: coef_two_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  adx_front #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data_byte (in_data_byte),
    .in_chan_sel  (in_chan_sel),
    .q_full       (q_full),
    .push         (push)
  );

  adx_fifo #(
    .DEPTH (adx_pkg::QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (q_full),
    .rd_valid (q_valid),
    .pop      (q_pop),
    .rd_item  (q_item)
  );

  adx_core #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_core (
    .clk              (clk),
    .rst_n            (rst_n),
    .coef_one         (coef_one_r),
    .coef_two         (coef_two_r),
    .q_valid          (q_valid),
    .q_item           (q_item),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_pcm_sample   (out_pcm_sample),
    .out_chan_out     (out_chan_out),
    .out_last_of_byte (out_last_of_byte)
  );

endmodule

// ----- hdl/adx_front.sv -----
// Front end: frame position tracking, scale capture and data byte dispatch.
module adx_front #(
  parameter int FRAME_BYTES = adx_pkg::FRAME_BYTES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [adx_pkg::BYTE_W-1:0]    in_data_byte,
  input  logic                          in_chan_sel,
  input  logic                          q_full,
  output adx_pkg::adx_push_t            push
);

  localparam int POS_W = $clog2(FRAME_BYTES);
  localparam logic [POS_W-1:0] POS_SCALE_HI = POS_W'(0);
  localparam logic [POS_W-1:0] POS_SCALE_LO = POS_W'(1);
  localparam logic [POS_W-1:0] POS_LAST     = POS_W'(FRAME_BYTES - 1);

  logic [POS_W-1:0]            pos_r, pos_nxt;
  logic [adx_pkg::SCALE_W-1:0] scale_r, scale_nxt;
  logic                        is_data;
  logic                        accept;

  assign is_data  = (pos_r != POS_SCALE_HI) && (pos_r != POS_SCALE_LO);
  assign in_stall = is_data && q_full;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    pos_nxt   = pos_r;
    scale_nxt = scale_r;
    if (accept) begin
      pos_nxt = (pos_r == POS_LAST) ? POS_SCALE_HI : pos_r + POS_W'(1);
      if (pos_r == POS_SCALE_HI) begin
        scale_nxt = {1'b0, in_data_byte, 8'h00};
      end else if (pos_r == POS_SCALE_LO) begin
        scale_nxt = {1'b0, scale_r[15:8], in_data_byte} + adx_pkg::SCALE_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= POS_SCALE_HI;
      scale_r <= '0;
    end else begin
      pos_r   <= pos_nxt;
      scale_r <= scale_nxt;
    end
  end

  assign push.valid          = accept && is_data;
  assign push.item.data_byte = in_data_byte;
  assign push.item.chan_sel  = in_chan_sel;
  assign push.item.scale     = scale_r;

endmodule

// ----- hdl/adx_fifo.sv -----
// Short queue of data bytes between the front end and the decode core.
module adx_fifo #(
  parameter int DEPTH = adx_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  adx_pkg::adx_push_t push,
  output logic               full,
  output logic               rd_valid,
  input  logic               pop,
  output adx_pkg::adx_item_t rd_item
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  adx_pkg::adx_item_t mem [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               do_wr, do_rd;

  assign full     = (cnt_r == CNT_W'(DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign do_wr    = push.valid && !full;
  assign do_rd    = pop && rd_valid;
  assign rd_item  = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr_r] <= push.item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      case ({do_wr, do_rd})
        2'b10:   cnt_r <= cnt_r + CNT_W'(1);
        2'b01:   cnt_r <= cnt_r - CNT_W'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

// ----- hdl/adx_core.sv -----
// Decode core: per-nibble prediction, saturation, channel history, output register.
module adx_core #(
  parameter int NUM_CHANNELS = adx_pkg::NUM_CHANNELS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [adx_pkg::COEF_W-1:0]        coef_one,
  input  logic signed [adx_pkg::COEF_W-1:0] coef_two,
  input  logic                              q_valid,
  input  adx_pkg::adx_item_t                q_item,
  output logic                              q_pop,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [adx_pkg::SAMPLE_W-1:0] out_pcm_sample,
  output logic                              out_chan_out,
  output logic                              out_last_of_byte
);

  localparam int CH_W   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int TERM_W = 22;
  localparam int PSUM_W = 31;
  localparam int SW     = adx_pkg::SAMPLE_W;

  typedef enum logic [1:0] {ST_IDLE, ST_HIGH, ST_LOW} state_t;

  state_t                 state_r, state_nxt;
  adx_pkg::adx_item_t     item_r;
  logic signed [SW-1:0]   hist_rec_r [NUM_CHANNELS];
  logic signed [SW-1:0]   hist_old_r [NUM_CHANNELS];
  logic                   out_valid_r;
  logic signed [SW-1:0]   out_sample_r;
  logic                   out_chan_r;
  logic                   out_last_r;

  logic                   active, fire, load;
  logic [CH_W-1:0]        ch_idx;
  logic [3:0]             nib;
  logic signed [20:0]     scale_term;
  logic signed [29:0]     prod_one;
  logic signed [28:0]     prod_two;
  logic signed [PSUM_W-1:0] psum;
  logic signed [TERM_W-1:0] sum;
  logic signed [SW-1:0]   sample;

  assign active = (state_r != ST_IDLE);
  assign fire   = active && (!out_valid_r || !out_stall);
  assign load   = q_valid && ((state_r == ST_IDLE) || ((state_r == ST_LOW) && fire));
  assign q_pop  = load;

  assign ch_idx = (32'(item_r.chan_sel) >= NUM_CHANNELS) ? CH_W'(NUM_CHANNELS - 1)
                                                         : CH_W'(item_r.chan_sel);
  assign nib = (state_r == ST_LOW) ? item_r.data_byte[3:0] : item_r.data_byte[7:4];

  assign scale_term = $signed(nib) * $signed({1'b0, item_r.scale});
  assign prod_one   = $signed({1'b0, coef_one}) * hist_rec_r[ch_idx];
  assign prod_two   = coef_two * hist_old_r[ch_idx];
  assign psum       = PSUM_W'(prod_one) + PSUM_W'(prod_two);
  assign sum        = TERM_W'(scale_term) + TERM_W'(psum >>> adx_pkg::PRED_SHIFT);

  always_comb begin
    if (sum > TERM_W'(adx_pkg::SAMPLE_MAX)) begin
      sample = SW'(adx_pkg::SAMPLE_MAX);
    end else if (sum < TERM_W'(adx_pkg::SAMPLE_MIN)) begin
      sample = SW'(adx_pkg::SAMPLE_MIN);
    end else begin
      sample = SW'(sum);
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (load) state_nxt = ST_HIGH;
      ST_HIGH: if (fire) state_nxt = ST_LOW;
      ST_LOW:  if (fire) state_nxt = load ? ST_HIGH : ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        hist_rec_r[i] <= '0;
        hist_old_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (load) begin
        item_r <= q_item;
      end
      if (fire) begin
        out_valid_r        <= 1'b1;
        out_sample_r       <= sample;
        out_chan_r         <= ch_idx[0];
        out_last_r         <= (state_r == ST_LOW);
        hist_old_r[ch_idx] <= hist_rec_r[ch_idx];
        hist_rec_r[ch_idx] <= sample;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_pcm_sample   = out_sample_r;
  assign out_chan_out     = out_chan_r;
  assign out_last_of_byte = out_last_r;

endmodule

// ----- hdl/adx_checker.sv -----
// Port-level assertions for the ADX ADPCM decoder, bound to the top level.
`include "adx_adpcm_decoder_defines.svh"

module adx_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [15:0] out_pcm_sample,
  input logic        out_chan_out,
  input logic        out_last_of_byte
);

  // A stalled beat holds.
  `ADX_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_pcm_sample) && $stable(out_chan_out) && $stable(out_last_of_byte), "stalled output beat changed")

  // The low-nibble sample of a byte follows its high-nibble sample directly.
  `ADX_ASSERT_NEXT(a_pair_next, out_valid && !out_stall && !out_last_of_byte, out_valid && out_last_of_byte, "low nibble sample did not follow high nibble")

  `ADX_ASSERT_NEXT(a_pair_chan, out_valid && !out_stall && !out_last_of_byte, out_chan_out == $past(out_chan_out), "channel changed within a byte")

  `ADX_ASSERT_NEXT_ALWAYS(a_rst_idle, !rst_n, !out_valid, "output valid right after reset")

endmodule

bind adx_adpcm_decoder adx_checker u_adx_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_pcm_sample   (out_pcm_sample),
  .out_chan_out     (out_chan_out),
  .out_last_of_byte (out_last_of_byte)
);
